// ===== rtl/core/chip8_pkg.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 core package
// Shared constants, transaction types and helper functions for the core.
// ----------------------------------------------------------------------------
package chip8_pkg;

  // Machine geometry.
  localparam int MemBytes    = 4096;
  localparam int MemAw       = 12;
  localparam int ProgStart   = 512;
  localparam int StackDepth  = 16;
  localparam int StackAw     = 4;
  localparam int ScreenRows  = 32;
  localparam int RowAw       = 5;
  localparam int ScreenCols  = 64;
  localparam int ColAw       = 6;
  localparam int KeyCount    = 16;
  localparam int FontBytes   = 80;

  // Action codes carried by an input transaction.
  typedef enum logic [2:0] {
    ACT_EXEC    = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_KEY     = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_LOAD    = 3'd5,
    ACT_ROW     = 3'd6,
    ACT_NOP     = 3'd7
  } action_e;

  // Latched fault codes.
  typedef enum logic [2:0] {
    FLT_NONE      = 3'd0,
    FLT_PC        = 3'd1,
    FLT_UNDERFLOW = 3'd2,
    FLT_OVERFLOW  = 3'd3,
    FLT_OPCODE    = 3'd4,
    FLT_KEY       = 3'd5,
    FLT_MEM       = 3'd6
  } fault_e;

  // Opcode groups and sub-codes.
  localparam logic [3:0] GrpSys  = 4'h0;
  localparam logic [3:0] GrpJp   = 4'h1;
  localparam logic [3:0] GrpCall = 4'h2;
  localparam logic [3:0] GrpSeI  = 4'h3;
  localparam logic [3:0] GrpSneI = 4'h4;
  localparam logic [3:0] GrpSeR  = 4'h5;
  localparam logic [3:0] GrpLdI  = 4'h6;
  localparam logic [3:0] GrpAddI = 4'h7;
  localparam logic [3:0] GrpAlu  = 4'h8;
  localparam logic [3:0] GrpSneR = 4'h9;
  localparam logic [3:0] GrpLdIx = 4'hA;
  localparam logic [3:0] GrpJpV0 = 4'hB;
  localparam logic [3:0] GrpRnd  = 4'hC;
  localparam logic [3:0] GrpDraw = 4'hD;
  localparam logic [3:0] GrpKey  = 4'hE;
  localparam logic [3:0] GrpMisc = 4'hF;

  localparam logic [7:0] KkCls   = 8'hE0;
  localparam logic [7:0] KkRet   = 8'hEE;
  localparam logic [7:0] KkSkp   = 8'h9E;
  localparam logic [7:0] KkSknp  = 8'hA1;
  localparam logic [7:0] KkGetDt = 8'h07;
  localparam logic [7:0] KkWait  = 8'h0A;
  localparam logic [7:0] KkSetDt = 8'h15;
  localparam logic [7:0] KkSetSt = 8'h18;
  localparam logic [7:0] KkAddI  = 8'h1E;
  localparam logic [7:0] KkFont  = 8'h29;
  localparam logic [7:0] KkBcd   = 8'h33;
  localparam logic [7:0] KkStore = 8'h55;
  localparam logic [7:0] KkLoad  = 8'h65;

  localparam logic [3:0] AluMov  = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  // Input and result transactions.
  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  key_number;
    logic [7:0]  random_byte;
    logic [11:0] rom_offset;
    logic [7:0]  rom_data;
    logic [4:0]  screen_row;
  } req_t;

  typedef struct packed {
    logic [15:0] pc_value;
    logic [2:0]  fault_kind;
    logic        waiting_key;
    logic        redraw;
    logic        sound_on;
    logic [3:0]  executed_group;
    logic [3:0]  upcoming_group;
    logic [63:0] row_pixels;
  } rsp_t;

  // Hex font glyph byte at the given address.
  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] font [FontBytes];
    font = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };
    if (32'(idx) < FontBytes) begin
      return font[idx];
    end
    return 8'h00;
  endfunction

  // True when len bytes from start lie inside memory.
  function automatic logic span_ok(input logic [15:0] start, input logic [4:0] len);
    logic [16:0] stop;
    stop = {1'b0, start} + {12'd0, len};
    return (32'(start) < MemBytes) && (32'(stop) <= MemBytes);
  endfunction

  // Decimal digit of an 8-bit value: 2 hundreds, 1 tens, 0 units.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    // Multiply by 205/2048 gives the tens digit for values below 100.
    p = 15'(r) * 15'd205;
    t = p[14:11];
    case (sel)
      2'd2:    return {6'd0, h};
      2'd1:    return {4'd0, t};
      default: return r - {t, 3'd0} - {3'd0, t, 1'b0};
    endcase
  endfunction

endpackage

// ===== rtl/core/chip8_ram.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module chip8_ram #(
  parameter int Depth = 16,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/chip8_interpreter_core.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 interpreter core
// Whole machine: memory, display, registers, stack, timers and keys, driven
// one action per transaction by a sequencer around synchronous RAMs.
//
//   Channel   Handshake               Payload
//   input     start & !busy           req_i  (chip8_pkg::req_t)
//   result    valid_o, one cycle      rsp_o  (chip8_pkg::rsp_t)
//
// Simple actions complete from idle; a row read adds a read state. An
// instruction runs fetch, execute and next-opcode states, with an extra state
// when it writes Vx after VF or returns from a subroutine, and ends early when it
// faults. A sprite loops per row, Fx55/Fx65 per register and 00E0 per display row,
// all set by the single memory and register-file ports. A program clear sweeps
// 3584 memory bytes, one per cycle. After reset a clearing pass loads the font
// and clears memory, display and V registers; busy is high meanwhile. The
// result cannot be stalled; the next transaction may start with it.
// ----------------------------------------------------------------------------
module chip8_interpreter_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  chip8_pkg::req_t req_i,
  output logic            valid_o,
  output chip8_pkg::rsp_t rsp_o
);

  import chip8_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_ROW, ST_F0, ST_F1, ST_F2, ST_EX, ST_WRX,
    ST_RET, ST_CLS, ST_SPR_RD, ST_SPR_WR, ST_SPR_FIN, ST_BCD, ST_ST_RD,
    ST_ST_WR, ST_LD_RD, ST_LD_WR, ST_NEXT, ST_NEXT_RD
  } state_e;

  state_e      state_q;
  logic [11:0] cnt_q;
  logic [15:0] pc_q, i_q;
  logic [4:0]  sp_q;
  logic [7:0]  dt_q, st_q, op_hi_q, op_lo_q, vx_q, vy_q, rnd_q;
  logic [15:0] keys_q;
  logic        waiting_q, redraw_q, coll_q, valid_q;
  logic [3:0]  wait_tgt_q, last_q, next_q;
  logic [2:0]  fault_q;
  logic [63:0] row_q;

  // RAM ports.
  logic             mem_we, disp_we, v_we, stk_we;
  logic [MemAw-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic [RowAw-1:0] disp_waddr, disp_raddr;
  logic [63:0]      disp_wdata, disp_rdata;
  logic [3:0]       v_waddr, v_raddr;
  logic [7:0]       v_wdata, v_rdata;
  logic [StackAw-1:0] stk_waddr, stk_raddr;
  logic [15:0]      stk_wdata, stk_rdata;

  chip8_ram #(.Depth(MemBytes), .Width(8)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );
  chip8_ram #(.Depth(ScreenRows), .Width(ScreenCols)) u_disp (
    .clk_i, .we_i(disp_we), .waddr_i(disp_waddr), .wdata_i(disp_wdata),
    .raddr_i(disp_raddr), .rdata_o(disp_rdata)
  );
  chip8_ram #(.Depth(16), .Width(8)) u_vreg (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );
  chip8_ram #(.Depth(StackDepth), .Width(16)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // Decoded instruction; a pending key wait overrides the fetched opcode.
  logic [3:0]  grp, ox, oy, on;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign grp = waiting_q ? GrpMisc : op_hi_q[7:4];
  assign ox  = waiting_q ? wait_tgt_q : op_hi_q[3:0];
  assign kk  = waiting_q ? KkWait : op_lo_q;
  assign oy  = op_lo_q[7:4];
  assign on  = op_lo_q[3:0];
  assign nnn = {op_hi_q[3:0], op_lo_q};

  logic accept;
  assign accept = start && !busy;

  // Arithmetic group: the flag is written first, so a flag register operand
  // sees the new flag when the result is formed.
  logic [8:0] add_full;
  logic       alu_flag, alu_flagged;
  logic [7:0] vxe, vye, alu_res;
  assign add_full = {1'b0, vx_q} + {1'b0, vy_q};
  always_comb begin
    alu_flagged = 1'b1;
    case (on)
      AluAdd:  alu_flag = add_full[8];
      AluSub:  alu_flag = vx_q > vy_q;
      AluShr:  alu_flag = vx_q[0];
      AluSubn: alu_flag = vy_q > vx_q;
      AluShl:  alu_flag = vx_q[7];
      default: begin
        alu_flag    = 1'b0;
        alu_flagged = 1'b0;
      end
    endcase
    vxe = (ox == 4'hF) ? {7'd0, alu_flag} : vx_q;
    vye = (oy == 4'hF) ? {7'd0, alu_flag} : vy_q;
    case (on)
      AluMov:  alu_res = vy_q;
      AluOr:   alu_res = vx_q | vy_q;
      AluAnd:  alu_res = vx_q & vy_q;
      AluXor:  alu_res = vx_q ^ vy_q;
      AluAdd:  alu_res = vxe + vye;
      AluSub:  alu_res = vxe - vye;
      AluShr:  alu_res = vxe >> 1;
      AluSubn: alu_res = vye - vxe;
      AluShl:  alu_res = vxe << 1;
      default: alu_res = vx_q;
    endcase
  end

  // Fx1E: the flag lands in VF first, so with x = F the flag itself is added.
  logic        addi_flag;
  logic [15:0] addi_opnd;
  assign addi_flag = ({1'b0, i_q} + {9'd0, vx_q}) > 17'h00FFF;
  assign addi_opnd = (ox == 4'hF) ? {15'd0, addi_flag} : {8'd0, vx_q};

  // Lowest pressed key.
  logic       key_any;
  logic [3:0] key_idx;
  always_comb begin
    key_any = |keys_q;
    key_idx = 4'd0;
    for (int k = KeyCount - 1; k >= 0; k--) begin
      if (keys_q[k]) begin
        key_idx = 4'(k);
      end
    end
  end

  // Sprite row mask, columns wrapping at the display edge.
  logic [7:0]   rev;
  logic [63:0]  base, mask;
  logic [6:0]   sh;
  logic [RowAw-1:0] spr_row;
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      rev[j] = mem_rdata[7-j];
    end
    base = {56'd0, rev};
    sh   = {1'b0, vx_q[ColAw-1:0]};
    mask = (base << sh) | (base >> (7'd64 - sh));
  end
  assign spr_row = vy_q[RowAw-1:0] + cnt_q[RowAw-1:0];

  logic [11:0] i_addr;
  assign i_addr = i_q[11:0] + cnt_q;

  logic [12:0] load_addr;
  assign load_addr = 13'(ProgStart) + {1'b0, req_i.rom_offset};

  // RAM port control.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = 8'd0;
    mem_raddr  = pc_q[11:0];
    disp_we    = 1'b0;
    disp_waddr = cnt_q[RowAw-1:0];
    disp_wdata = '0;
    disp_raddr = req_i.screen_row;
    v_we       = 1'b0;
    v_waddr    = ox;
    v_wdata    = 8'd0;
    v_raddr    = 4'd0;
    stk_we     = 1'b0;
    stk_waddr  = sp_q[StackAw-1:0];
    stk_wdata  = pc_q + 16'd2;
    stk_raddr  = StackAw'(sp_q - 5'd1);
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (32'(cnt_q) < FontBytes) ? font_byte(cnt_q[6:0]) : 8'd0;
        disp_we   = 32'(cnt_q) < ScreenRows;
        v_we      = cnt_q < 12'd16;
        v_waddr   = cnt_q[3:0];
      end
      ST_IDLE: begin
        if (accept && req_i.action == ACT_LOAD && 32'(load_addr) < MemBytes) begin
          mem_we    = 1'b1;
          mem_waddr = load_addr[11:0];
          mem_wdata = req_i.rom_data;
        end
      end
      ST_CLR: mem_we = 1'b1;
      ST_F0: begin
        mem_raddr = pc_q[11:0] + 12'd1;
        v_raddr   = waiting_q ? wait_tgt_q : mem_rdata[3:0];
      end
      ST_F1: v_raddr = (op_hi_q[7:4] == GrpJpV0) ? 4'd0 : mem_rdata[7:4];
      ST_EX: begin
        case (grp)
          GrpCall: stk_we = (32'(sp_q) < StackDepth) && span_ok({4'd0, nnn}, 5'd2);
          GrpLdI: begin
            v_we    = 1'b1;
            v_wdata = kk;
          end
          GrpAddI: begin
            v_we    = 1'b1;
            v_wdata = vx_q + kk;
          end
          GrpRnd: begin
            v_we    = 1'b1;
            v_wdata = rnd_q & kk;
          end
          GrpAlu: begin
            v_we    = alu_flagged || on == AluMov || on == AluOr || on == AluAnd ||
                      on == AluXor;
            v_waddr = alu_flagged ? 4'hF : ox;
            v_wdata = alu_flagged ? {7'd0, alu_flag} : alu_res;
          end
          GrpDraw: begin
            v_we    = 1'b1;
            v_waddr = 4'hF;
          end
          GrpMisc: begin
            if (kk == KkGetDt) begin
              v_we    = 1'b1;
              v_wdata = dt_q;
            end else if (kk == KkWait) begin
              v_we    = key_any;
              v_wdata = {4'd0, key_idx};
            end else if (kk == KkAddI) begin
              v_we    = 1'b1;
              v_waddr = 4'hF;
              v_wdata = {7'd0, addi_flag};
            end
          end
          default: ;
        endcase
      end
      ST_WRX: begin
        v_we    = 1'b1;
        v_wdata = alu_res;
      end
      ST_CLS: disp_we = 1'b1;
      ST_SPR_RD: begin
        mem_raddr  = i_addr;
        disp_raddr = spr_row;
      end
      ST_SPR_WR: begin
        disp_we    = 1'b1;
        disp_waddr = spr_row;
        disp_wdata = disp_rdata ^ mask;
      end
      ST_SPR_FIN: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, coll_q};
      end
      ST_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = i_addr;
        mem_wdata = bcd_digit(vx_q, 2'd2 - cnt_q[1:0]);
      end
      ST_ST_RD: v_raddr = cnt_q[3:0];
      ST_ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_addr;
        mem_wdata = v_rdata;
      end
      ST_LD_RD: mem_raddr = i_addr;
      ST_LD_WR: begin
        v_we    = 1'b1;
        v_waddr = cnt_q[3:0];
        v_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  assign busy    = state_q != ST_IDLE;
  assign valid_o = valid_q;
  assign rsp_o   = '{pc_value: pc_q, fault_kind: fault_q, waiting_key: waiting_q,
                     redraw: redraw_q, sound_on: |st_q, executed_group: last_q,
                     upcoming_group: next_q, row_pixels: row_q};

  // Sequencer and machine registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      cnt_q      <= '0;
      pc_q       <= 16'(ProgStart);
      i_q        <= '0;
      sp_q       <= '0;
      dt_q       <= '0;
      st_q       <= '0;
      keys_q     <= '0;
      waiting_q  <= 1'b0;
      wait_tgt_q <= '0;
      fault_q    <= FLT_NONE;
      last_q     <= '0;
      next_q     <= '0;
      redraw_q   <= 1'b0;
      coll_q     <= 1'b0;
      valid_q    <= 1'b0;
      row_q      <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + 12'd1;
          if (32'(cnt_q) == MemBytes - 1) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            redraw_q <= 1'b0;
            row_q    <= '0;
            rnd_q    <= req_i.random_byte;
            case (req_i.action)
              ACT_EXEC: begin
                if (fault_q != FLT_NONE) begin
                  valid_q <= 1'b1;
                end else if (!span_ok(pc_q, 5'd2)) begin
                  fault_q   <= FLT_PC;
                  waiting_q <= 1'b0;
                  redraw_q  <= 1'b1;
                  valid_q   <= 1'b1;
                end else begin
                  state_q <= ST_F0;
                end
              end
              ACT_TICK: begin
                if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
                if (st_q != 8'd0) st_q <= st_q - 8'd1;
                valid_q <= 1'b1;
              end
              ACT_KEY: begin
                keys_q[req_i.key_number] <= 1'b1;
                valid_q <= 1'b1;
              end
              ACT_RELEASE: begin
                keys_q  <= '0;
                valid_q <= 1'b1;
              end
              ACT_CLEAR: begin
                cnt_q   <= 12'(ProgStart);
                state_q <= ST_CLR;
              end
              ACT_ROW: state_q <= ST_ROW;
              default: valid_q <= 1'b1;
            endcase
          end
        end

        // Program area wipe, then machine control state back to start.
        ST_CLR: begin
          cnt_q <= cnt_q + 12'd1;
          if (32'(cnt_q) == MemBytes - 1) begin
            pc_q      <= 16'(ProgStart);
            sp_q      <= '0;
            waiting_q <= 1'b0;
            fault_q   <= FLT_NONE;
            valid_q   <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end

        // Every 5-bit row number lies on the display, so the row is returned as read.
        ST_ROW: begin
          row_q   <= disp_rdata;
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end

        // Opcode fetch and operand reads.
        ST_F0: begin
          op_hi_q <= mem_rdata;
          state_q <= ST_F1;
        end
        ST_F1: begin
          op_lo_q <= mem_rdata;
          vx_q    <= v_rdata;
          state_q <= ST_F2;
        end
        ST_F2: begin
          vy_q    <= v_rdata;
          state_q <= ST_EX;
        end

        ST_EX: begin
          last_q  <= grp;
          state_q <= ST_NEXT;
          case (grp)
            GrpSys: begin
              if (kk == KkCls) begin
                pc_q    <= pc_q + 16'd2;
                cnt_q   <= '0;
                state_q <= ST_CLS;
              end else if (kk == KkRet) begin
                if (sp_q == 5'd0) begin
                  fault_q  <= FLT_UNDERFLOW;
                  redraw_q <= 1'b1;
                  valid_q  <= 1'b1;
                  state_q  <= ST_IDLE;
                end else begin
                  sp_q    <= sp_q - 5'd1;
                  state_q <= ST_RET;
                end
              end else begin
                fault_q  <= FLT_OPCODE;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end
            end
            GrpJp: begin
              if (span_ok({4'd0, nnn}, 5'd2)) begin
                pc_q <= {4'd0, nnn};
              end else begin
                fault_q  <= FLT_PC;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end
            end
            GrpCall: begin
              if (32'(sp_q) >= StackDepth) begin
                fault_q  <= FLT_OVERFLOW;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end else if (!span_ok({4'd0, nnn}, 5'd2)) begin
                fault_q  <= FLT_PC;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end else begin
                sp_q <= sp_q + 5'd1;
                pc_q <= {4'd0, nnn};
              end
            end
            GrpSeI:  pc_q <= pc_q + ((vx_q == kk) ? 16'd4 : 16'd2);
            GrpSneI: pc_q <= pc_q + ((vx_q != kk) ? 16'd4 : 16'd2);
            GrpSeR:  pc_q <= pc_q + ((vx_q == vy_q) ? 16'd4 : 16'd2);
            GrpLdI, GrpAddI, GrpRnd: pc_q <= pc_q + 16'd2;
            GrpAlu: begin
              if (alu_flagged) begin
                pc_q    <= pc_q + 16'd2;
                state_q <= ST_WRX;
              end else if (on == AluMov || on == AluOr || on == AluAnd || on == AluXor) begin
                pc_q <= pc_q + 16'd2;
              end else begin
                fault_q  <= FLT_OPCODE;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end
            end
            GrpSneR: begin
              if (on == 4'd0) begin
                pc_q <= pc_q + ((vx_q != vy_q) ? 16'd4 : 16'd2);
              end else begin
                fault_q  <= FLT_OPCODE;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end
            end
            GrpLdIx: begin
              i_q  <= {4'd0, nnn};
              pc_q <= pc_q + 16'd2;
            end
            GrpJpV0: begin
              if (span_ok({4'd0, nnn} + {8'd0, vy_q}, 5'd2)) begin
                pc_q <= {4'd0, nnn} + {8'd0, vy_q};
              end else begin
                fault_q  <= FLT_PC;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end
            end
            GrpDraw: begin
              redraw_q <= 1'b1;
              if (!span_ok(i_q, {1'b0, on})) begin
                fault_q <= FLT_MEM;
                valid_q <= 1'b1;
                state_q <= ST_IDLE;
              end else begin
                pc_q   <= pc_q + 16'd2;
                cnt_q  <= '0;
                coll_q <= 1'b0;
                if (on != 4'd0) begin
                  state_q <= ST_SPR_RD;
                end
              end
            end
            GrpKey: begin
              if (kk == KkSkp || kk == KkSknp) begin
                if (32'(vx_q) >= KeyCount) begin
                  fault_q  <= FLT_KEY;
                  redraw_q <= 1'b1;
                  valid_q  <= 1'b1;
                  state_q  <= ST_IDLE;
                end else begin
                  pc_q <= pc_q + (((kk == KkSkp) == keys_q[vx_q[3:0]]) ? 16'd4 : 16'd2);
                end
              end else begin
                fault_q  <= FLT_OPCODE;
                redraw_q <= 1'b1;
                valid_q  <= 1'b1;
                state_q  <= ST_IDLE;
              end
            end
            default: begin
              case (kk)
                KkGetDt: pc_q <= pc_q + 16'd2;
                KkWait: begin
                  wait_tgt_q <= ox;
                  if (key_any) begin
                    waiting_q <= 1'b0;
                    pc_q      <= pc_q + 16'd2;
                  end else begin
                    waiting_q <= 1'b1;
                    valid_q   <= 1'b1;
                    state_q   <= ST_IDLE;
                  end
                end
                KkSetDt: begin
                  dt_q <= vx_q;
                  pc_q <= pc_q + 16'd2;
                end
                KkSetSt: begin
                  st_q <= vx_q;
                  pc_q <= pc_q + 16'd2;
                end
                KkAddI: begin
                  i_q  <= i_q + addi_opnd;
                  pc_q <= pc_q + 16'd2;
                end
                KkFont: begin
                  i_q  <= {6'd0, vx_q, 2'b00} + {8'd0, vx_q};
                  pc_q <= pc_q + 16'd2;
                end
                KkBcd, KkStore, KkLoad: begin
                  if (!span_ok(i_q, (kk == KkBcd) ? 5'd3 : ({1'b0, ox} + 5'd1))) begin
                    fault_q  <= FLT_MEM;
                    redraw_q <= 1'b1;
                    valid_q  <= 1'b1;
                    state_q  <= ST_IDLE;
                  end else begin
                    cnt_q   <= '0;
                    state_q <= (kk == KkBcd) ? ST_BCD : ((kk == KkStore) ? ST_ST_RD : ST_LD_RD);
                  end
                end
                default: begin
                  fault_q  <= FLT_OPCODE;
                  redraw_q <= 1'b1;
                  valid_q  <= 1'b1;
                  state_q  <= ST_IDLE;
                end
              endcase
            end
          endcase
        end

        ST_WRX: state_q <= ST_NEXT;

        ST_RET: begin
          pc_q    <= stk_rdata;
          state_q <= ST_NEXT;
        end

        ST_CLS: begin
          cnt_q <= cnt_q + 12'd1;
          if (32'(cnt_q) == ScreenRows - 1) begin
            state_q <= ST_NEXT;
          end
        end

        // Sprite rows: read pattern and display row, then write back.
        ST_SPR_RD: state_q <= ST_SPR_WR;
        ST_SPR_WR: begin
          if ((disp_rdata & mask) != '0) begin
            coll_q <= 1'b1;
          end
          cnt_q   <= cnt_q + 12'd1;
          state_q <= (cnt_q[3:0] == on - 4'd1) ? ST_SPR_FIN : ST_SPR_RD;
        end
        ST_SPR_FIN: state_q <= ST_NEXT;

        ST_BCD: begin
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q[1:0] == 2'd2) begin
            pc_q    <= pc_q + 16'd2;
            state_q <= ST_NEXT;
          end
        end

        // Block register store and load, a read state and a write state per register.
        ST_ST_RD: state_q <= ST_ST_WR;
        ST_LD_RD: state_q <= ST_LD_WR;
        ST_ST_WR, ST_LD_WR: begin
          cnt_q <= cnt_q + 12'd1;
          if (cnt_q[3:0] == ox) begin
            i_q     <= i_q + {11'd0, {1'b0, ox} + 5'd1};
            pc_q    <= pc_q + 16'd2;
            state_q <= ST_NEXT;
          end else begin
            state_q <= (state_q == ST_ST_WR) ? ST_ST_RD : ST_LD_RD;
          end
        end

        // Peek at the next opcode group.
        ST_NEXT: begin
          if (!span_ok(pc_q, 5'd2)) begin
            fault_q   <= FLT_PC;
            waiting_q <= 1'b0;
            redraw_q  <= 1'b1;
            valid_q   <= 1'b1;
            state_q   <= ST_IDLE;
          end else begin
            state_q <= ST_NEXT_RD;
          end
        end
        ST_NEXT_RD: begin
          next_q  <= mem_rdata[7:4];
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/chip8_interpreter_core_checker.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 core transaction checker
// Watches the input and result channels of the core, keeps its own model of
// the machine, works out the result of every accepted input transaction and
// compares each result strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module chip8_interpreter_core_checker
  import chip8_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  busy_i,
  input  req_t  req_i,
  input  logic  valid_i,
  input  rsp_t  rsp_i,
  output int    fail_count_o,
  output int    pending_o
);

  // Machine state as the core should hold it.
  logic [7:0]  mem [MemBytes];
  logic [63:0] disp [ScreenRows];
  logic [7:0]  v [16];
  logic [15:0] stk [StackDepth];
  int          sp;
  logic [15:0] pc;
  logic [15:0] ix;
  logic [7:0]  dt;
  logic [7:0]  st;
  logic        keys [KeyCount];
  logic        waitf;
  logic [3:0]  waitt;
  logic [2:0]  flt;
  logic [3:0]  lastg;
  logic [3:0]  nextg;
  logic        redraw;
  int          fails = 0;

  rsp_t        rsp_q [$];

  assign pending_o    = rsp_q.size();
  assign fail_count_o = fails;

  function automatic bit fits(input int s, input int len);
    return (s < MemBytes) && (len <= MemBytes - s);
  endfunction

  task automatic machine_reset();
    logic [7:0] glyph [80];
    glyph = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };
    for (int i = 0; i < MemBytes; i++) mem[i] = (i < 80) ? glyph[i] : 8'h00;
    for (int i = 0; i < ScreenRows; i++) disp[i] = '0;
    for (int i = 0; i < 16; i++) begin
      v[i] = '0;
      stk[i] = '0;
      keys[i] = 1'b0;
    end
    sp = 0;
    pc = 16'(ProgStart);
    ix = '0;
    dt = '0;
    st = '0;
    waitf = 1'b0;
    waitt = '0;
    flt = FLT_NONE;
    lastg = '0;
    nextg = '0;
    redraw = 1'b0;
  endtask

  task automatic raise(input fault_e kind);
    flt = kind;
    waitf = 1'b0;
    redraw = 1'b1;
  endtask

  // Sprite draw with wrapping at both display edges; VF is cleared first.
  task automatic draw(input logic [7:0] col, input logic [7:0] row, input logic [3:0] n,
                      output bit ok);
    logic [7:0] pat;
    int r;
    int c;
    v[15] = 8'h00;
    ok = fits(ix, n);
    if (!ok) begin
      raise(FLT_MEM);
      return;
    end
    for (int b = 0; b < n; b++) begin
      pat = mem[ix + b];
      r = (row + b) % ScreenRows;
      for (int bt = 0; bt < 8; bt++) begin
        c = (col + 7 - bt) % ScreenCols;
        if (pat[bt]) begin
          if (disp[r][c]) v[15] = 8'h01;
          disp[r][c] = ~disp[r][c];
        end
      end
    end
  endtask

  // One instruction, or the pending key wait when one is outstanding.
  task automatic run_instruction(input logic [7:0] rnd);
    logic [15:0] op;
    logic [15:0] tgt;
    logic [11:0] nnn;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    bit          ok;
    bit          down;
    if (flt != FLT_NONE) return;
    if (!fits(pc, 2)) begin
      raise(FLT_PC);
      return;
    end
    op = {mem[pc], mem[pc + 1]};
    x = op[11:8];
    y = op[7:4];
    n = op[3:0];
    kk = op[7:0];
    nnn = op[11:0];
    if (waitf) begin
      op = 16'hF000;
      kk = KkWait;
      x = waitt;
    end
    lastg = op[15:12];
    case (op[15:12])
      GrpSys: begin
        if (kk == KkCls) begin
          for (int i = 0; i < ScreenRows; i++) disp[i] = '0;
          pc += 16'd2;
        end else if (kk == KkRet) begin
          if (sp == 0) raise(FLT_UNDERFLOW);
          else begin
            sp--;
            pc = stk[sp % StackDepth];
          end
        end else raise(FLT_OPCODE);
      end
      GrpJp: begin
        if (!fits(nnn, 2)) raise(FLT_PC);
        else pc = 16'(nnn);
      end
      GrpCall: begin
        if (sp >= StackDepth) raise(FLT_OVERFLOW);
        else if (!fits(nnn, 2)) raise(FLT_PC);
        else begin
          stk[sp] = pc + 16'd2;
          sp++;
          pc = 16'(nnn);
        end
      end
      GrpSeI:  pc += (v[x] == kk) ? 16'd4 : 16'd2;
      GrpSneI: pc += (v[x] != kk) ? 16'd4 : 16'd2;
      GrpSeR:  pc += (v[x] == v[y]) ? 16'd4 : 16'd2;
      GrpLdI: begin
        v[x] = kk;
        pc += 16'd2;
      end
      GrpAddI: begin
        v[x] = v[x] + kk;
        pc += 16'd2;
      end
      GrpAlu: begin
        // The flag is written before Vx, so x = F overwrites it.
        case (n)
          AluMov: v[x] = v[y];
          AluOr:  v[x] = v[x] | v[y];
          AluAnd: v[x] = v[x] & v[y];
          AluXor: v[x] = v[x] ^ v[y];
          AluAdd: begin
            v[15] = ({1'b0, v[x]} + {1'b0, v[y]} > 9'd255) ? 8'd1 : 8'd0;
            v[x] = v[x] + v[y];
          end
          AluSub: begin
            v[15] = (v[x] > v[y]) ? 8'd1 : 8'd0;
            v[x] = v[x] - v[y];
          end
          AluShr: begin
            v[15] = {7'd0, v[x][0]};
            v[x] = v[x] >> 1;
          end
          AluSubn: begin
            v[15] = (v[y] > v[x]) ? 8'd1 : 8'd0;
            v[x] = v[y] - v[x];
          end
          AluShl: begin
            v[15] = {7'd0, v[x][7]};
            v[x] = v[x] << 1;
          end
          default: raise(FLT_OPCODE);
        endcase
        if (flt == FLT_NONE) pc += 16'd2;
      end
      GrpSneR: begin
        if (n == 4'd0) pc += (v[x] != v[y]) ? 16'd4 : 16'd2;
        else raise(FLT_OPCODE);
      end
      GrpLdIx: begin
        ix = 16'(nnn);
        pc += 16'd2;
      end
      GrpJpV0: begin
        tgt = 16'(nnn) + 16'(v[0]);
        if (!fits(tgt, 2)) raise(FLT_PC);
        else pc = tgt;
      end
      GrpRnd: begin
        v[x] = rnd & kk;
        pc += 16'd2;
      end
      GrpDraw: begin
        draw(v[x], v[y], n, ok);
        if (ok) begin
          redraw = 1'b1;
          pc += 16'd2;
        end
      end
      GrpKey: begin
        if (kk == KkSkp || kk == KkSknp) begin
          if (v[x] >= KeyCount) raise(FLT_KEY);
          else begin
            down = keys[v[x]];
            pc += (((kk == KkSkp) ? down : !down)) ? 16'd4 : 16'd2;
          end
        end else raise(FLT_OPCODE);
      end
      default: begin
        case (kk)
          KkGetDt: begin
            v[x] = dt;
            pc += 16'd2;
          end
          KkWait: begin
            // Lowest pressed key wins; with none, the core keeps waiting.
            waitf = 1'b1;
            waitt = x;
            for (int i = 0; i < KeyCount; i++) begin
              if (keys[i]) begin
                v[x] = 8'(i);
                waitf = 1'b0;
                pc += 16'd2;
                break;
              end
            end
            if (waitf) return;
          end
          KkSetDt: begin
            dt = v[x];
            pc += 16'd2;
          end
          KkSetSt: begin
            st = v[x];
            pc += 16'd2;
          end
          KkAddI: begin
            v[15] = ((32'(ix) + 32'(v[x])) > 32'hFFF) ? 8'd1 : 8'd0;
            ix = ix + 16'(v[x]);
            pc += 16'd2;
          end
          KkFont: begin
            ix = 16'(5 * 32'(v[x]));
            pc += 16'd2;
          end
          KkBcd: begin
            if (!fits(ix, 3)) raise(FLT_MEM);
            else begin
              mem[ix]     = v[x] / 100;
              mem[ix + 1] = (v[x] % 100) / 10;
              mem[ix + 2] = v[x] % 10;
              pc += 16'd2;
            end
          end
          KkStore, KkLoad: begin
            if (!fits(ix, x + 1)) raise(FLT_MEM);
            else begin
              for (int i = 0; i <= x; i++) begin
                if (kk == KkStore) mem[ix + i] = v[i];
                else v[i] = mem[ix + i];
              end
              ix = ix + 16'(x) + 16'd1;
              pc += 16'd2;
            end
          end
          default: raise(FLT_OPCODE);
        endcase
      end
    endcase
    if (flt != FLT_NONE) return;
    if (!fits(pc, 2)) begin
      raise(FLT_PC);
      return;
    end
    nextg = mem[pc][7:4];
  endtask

  // Applies one input transaction and forms the result it should produce.
  task automatic predict_result(input req_t r, output rsp_t e);
    int addr;
    logic [63:0] row;
    row = '0;
    redraw = 1'b0;
    case (action_e'(r.action))
      ACT_EXEC: run_instruction(r.random_byte);
      ACT_TICK: begin
        if (dt > 0) dt--;
        if (st > 0) st--;
      end
      ACT_KEY: keys[r.key_number] = 1'b1;
      ACT_RELEASE: for (int i = 0; i < KeyCount; i++) keys[i] = 1'b0;
      ACT_CLEAR: begin
        for (int i = ProgStart; i < MemBytes; i++) mem[i] = 8'h00;
        pc = 16'(ProgStart);
        sp = 0;
        waitf = 1'b0;
        flt = FLT_NONE;
      end
      ACT_LOAD: begin
        addr = ProgStart + r.rom_offset;
        if (addr < MemBytes) mem[addr] = r.rom_data;
      end
      ACT_ROW: if (r.screen_row < ScreenRows) row = disp[r.screen_row];
      default: ;
    endcase
    e.pc_value = pc;
    e.fault_kind = flt;
    e.waiting_key = waitf;
    e.redraw = redraw;
    e.sound_on = (st != 0);
    e.executed_group = lastg;
    e.upcoming_group = nextg;
    e.row_pixels = row;
  endtask

  initial begin
    machine_reset();
  end

  // Predict on every accepted input, then check every result strobe.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        predict_result(req_i, want);
        rsp_q.push_back(want);
      end
      if (valid_i) begin
        if (rsp_q.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", rsp_i);
          fails++;
        end else begin
          want = rsp_q.pop_front();
          if (rsp_i.pc_value !== want.pc_value ||
              rsp_i.fault_kind !== want.fault_kind ||
              rsp_i.waiting_key !== want.waiting_key ||
              rsp_i.redraw !== want.redraw ||
              rsp_i.sound_on !== want.sound_on ||
              rsp_i.executed_group !== want.executed_group ||
              rsp_i.upcoming_group !== want.upcoming_group ||
              rsp_i.row_pixels !== want.row_pixels) begin
            if (fails < 10) begin
              $display("mismatch: pc %h/%h fault %0d/%0d wait %b/%b redraw %b/%b",
                       want.pc_value, rsp_i.pc_value, want.fault_kind, rsp_i.fault_kind,
                       want.waiting_key, rsp_i.waiting_key, want.redraw, rsp_i.redraw);
              $display("  sound %b/%b groups %h%h/%h%h row %h/%h",
                       want.sound_on, rsp_i.sound_on, want.executed_group,
                       want.upcoming_group, rsp_i.executed_group, rsp_i.upcoming_group,
                       want.row_pixels, rsp_i.row_pixels);
            end
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== test/chip8_interpreter_core_test.sv =====
// ----------------------------------------------------------------------------
// CHIP-8 core testbench
// Loads short random programs into the core and runs them, mixed with timer
// ticks, key events, display reads and stray stores, under several sender
// idle patterns. A checker beside the core predicts and compares results.
// ----------------------------------------------------------------------------
module chip8_interpreter_core_test;
  import chip8_pkg::*;

  localparam int WatchLimit = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic valid_o;
  rsp_t rsp_o;
  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   items = 0;
  int   quiet = 0;

  chip8_interpreter_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  chip8_interpreter_core_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .valid_i     (valid_o),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Random filler in every field, with the chosen action.
  function automatic req_t make_req(input action_e act);
    req_t r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.action = act;
    return r;
  endfunction

  // Drives one transaction and waits for it to be taken, then maybe idles.
  // Busy only moves at a rising edge, so it is looked at on the falling edge before.
  task automatic issue(input req_t r);
    start <= 1'b1;
    req_i <= r;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    items++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic load_byte(input int off, input logic [7:0] data);
    req_t r;
    r = make_req(ACT_LOAD);
    r.rom_offset = 12'(off);
    r.rom_data = data;
    issue(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed instructions, jump targets mostly inside the loaded program.
  function automatic logic [15:0] make_op();
    logic [3:0]  g;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [3:0]  alu [9];
    logic [7:0]  misc [9];
    alu = '{AluMov, AluOr, AluAnd, AluXor, AluAdd, AluSub, AluShr, AluSubn, AluShl};
    misc = '{KkGetDt, KkWait, KkSetDt, KkSetSt, KkAddI, KkFont, KkBcd, KkStore, KkLoad};
    g = 4'($urandom_range(0, 15));
    x = 4'($urandom);
    y = 4'($urandom);
    n = 4'($urandom);
    kk = 8'($urandom);
    nnn = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                      : 12'(ProgStart + 2 * $urandom_range(0, 31));
    case (g)
      GrpSys: begin
        case ($urandom_range(0, 4))
          0, 1: return {GrpSys, 4'h0, KkCls};
          2, 3: return {GrpSys, 4'h0, KkRet};
          default: return {GrpSys, x, kk};
        endcase
      end
      GrpJp, GrpCall, GrpJpV0: return {g, nnn};
      GrpAlu: begin
        if ($urandom_range(0, 9) != 0) n = alu[$urandom_range(0, 8)];
        return {g, x, y, n};
      end
      GrpSneR: return {g, x, y, ($urandom_range(0, 9) == 0) ? n : 4'h0};
      GrpLdIx: begin
        case ($urandom_range(0, 3))
          0, 1: nnn = 12'(12'h300 + $urandom_range(0, 12'h3FF));
          2: nnn = 12'($urandom_range(0, 79));
          default: ;
        endcase
        return {g, nnn};
      end
      GrpKey: begin
        if ($urandom_range(0, 9) != 0) kk = $urandom_range(0, 1) ? KkSkp : KkSknp;
        return {g, x, kk};
      end
      GrpMisc: begin
        if ($urandom_range(0, 9) != 0) kk = misc[$urandom_range(0, 8)];
        return {g, x, kk};
      end
      default: return {g, x, kk};
    endcase
  endfunction

  initial begin
    req_t r;
    logic [15:0] op;
    int ep;
    int pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a small program with carry, field extremes and a bad opcode.
    load_byte(0, 8'h60);
    load_byte(1, 8'hFF);
    load_byte(2, 8'h80);
    load_byte(3, 8'h04);
    load_byte(3583, 8'hA5);
    load_byte(4095, 8'h5A);
    issue(make_req(ACT_EXEC));
    issue(make_req(ACT_EXEC));
    r = make_req(ACT_ROW);
    r.screen_row = 5'd0;
    issue(r);
    r.screen_row = 5'd31;
    issue(r);
    r = make_req(ACT_KEY);
    r.key_number = 4'd15;
    issue(r);
    r.key_number = 4'd0;
    issue(r);
    issue(make_req(ACT_RELEASE));
    issue(make_req(ACT_TICK));
    issue(make_req(ACT_NOP));
    issue(make_req(ACT_EXEC));
    issue(make_req(ACT_EXEC));
    issue(make_req(ACT_CLEAR));

    // Random episodes: clear, load a program, then run it among other events.
    ep = 0;
    while (items < 1350) begin
      drain();
      idle_pct = (ep % 3 == 0) ? 0 : ((ep % 3 == 1) ? 63 : 11);
      issue(make_req(ACT_CLEAR));
      for (int i = 0; i < 32; i++) begin
        op = make_op();
        load_byte(2 * i, op[15:8]);
        load_byte(2 * i + 1, op[7:0]);
      end
      for (int i = 0; i < 70; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) r = make_req(ACT_EXEC);
        else if (pick < 78) r = make_req(ACT_TICK);
        else if (pick < 86) r = make_req(ACT_KEY);
        else if (pick < 89) r = make_req(ACT_RELEASE);
        else if (pick < 95) r = make_req(ACT_ROW);
        else if (pick < 99) r = make_req(ACT_LOAD);
        else r = make_req(ACT_NOP);
        issue(r);
      end
      ep++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
